/* hw/rtl/fsgs_pkg.sv */
// ----------------------------------------------------------------------------
// fsgs_pkg
// Shared types and constants for the fire spread grid step block.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  // request codes
  localparam logic [1:0] REQ_RESTART = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_IGN_ROW   = 3'd0;
  localparam logic [2:0] CFG_IGN_COL   = 3'd1;
  localparam logic [2:0] CFG_IGN_RATE  = 3'd2;
  localparam logic [2:0] CFG_TIME_STEP = 3'd3;
  localparam logic [2:0] CFG_BASE_DIST = 3'd4;

  localparam int NDIR = 8;
  localparam logic [15:0] SQRT2_Q15 = 16'd46341;

  // neighbor offsets, destination = source + (DROW, DCOL)
  localparam int DROW [NDIR] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int DCOL [NDIR] = '{0, 1, 1, 1, 0, -1, -1, -1};

  // directions ordered by source scan position, lowest first
  localparam int PRIO [NDIR] = '{1, 0, 7, 2, 6, 3, 4, 5};

  typedef struct packed {
    logic        burn;
    logic [15:0] rate;
    logic [15:0] arrival;
  } cell_t;

  typedef struct packed {
    logic        burn;
    logic [15:0] rate;
    logic [15:0] dec;
  } win_t;

endpackage

/* hw/rtl/fire_spread_grid_step_top.sv */
// ----------------------------------------------------------------------------
// fire_spread_grid_step_top
// Fire spread cellular automaton over a ROWS x COLS grid, 8 neighbors, Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on in_valid/in_ready (req_type, cell_row, cell_col).
//   Every request produces exactly one result transfer on out_valid/out_ready
//   (arrival_step, ignited, step_count). Registers are written over the
//   cfg_valid/cfg_ready channel (cfg_index, cfg_data); cfg_ready is always high.
//   One request is worked at a time; in_ready is low from acceptance until
//   its result has been transferred.
// Operation:
//   read    : one cell memory read
//   restart : one entry of both memories filled a cycle
//   advance : the scan streams the cell memory
//             through a two-row line buffer and handles one destination cell
//             a cycle, all eight incoming directions together; the distance
//             memory holds the eight distances of a cell in one word.
// Reset:
//   A clearing pass zeroes the cell memory; in_ready is low during it.
//   Distances stay undefined until the first restart.
// Stall:
//   A held result blocks the next request; nothing is dropped.
// ----------------------------------------------------------------------------
module fire_spread_grid_step_top #(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [6:0]  cell_row,
  input  logic [6:0]  cell_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] arrival_step,
  output logic        ignited,
  output logic [15:0] step_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CNTW  = $clog2(CELLS + COLS + 4);
  localparam int WLEN  = 2 * COLS + 3;
  localparam int DW    = 16 * fsgs_pkg::NDIR;

  localparam logic [CNTW-1:0] CNT_FILL_END = CNTW'(CELLS - 1);
  localparam logic [CNTW-1:0] CNT_PROC_LO  = CNTW'(COLS + 3);
  localparam logic [CNTW-1:0] CNT_ADV_END  = CNTW'(CELLS + COLS + 2);
  localparam logic [CNTW-1:0] CNT_DRD_OFS  = CNTW'(COLS + 2);
  localparam logic [CNTW-1:0] CNT_DST_OFS  = CNTW'(COLS + 3);
  localparam logic [RW-1:0]   ROW_LAST     = RW'(ROWS - 1);
  localparam logic [CW-1:0]   COL_LAST     = CW'(COLS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_FILL, S_ADV
  } state_t;

  state_t state;

  // configuration
  logic [6:0]  ign_row;
  logic [6:0]  ign_col;
  logic [15:0] ign_rate;
  logic [15:0] time_step;
  logic [15:0] base_dist;
  logic [15:0] diag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ign_row   <= 7'd52;
      ign_col   <= 7'd50;
      ign_rate  <= 16'd512;
      time_step <= 16'd128;
      base_dist <= 16'd1280;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsgs_pkg::CFG_IGN_ROW:   ign_row   <= cfg_data[6:0];
        fsgs_pkg::CFG_IGN_COL:   ign_col   <= cfg_data[6:0];
        fsgs_pkg::CFG_IGN_RATE:  ign_rate  <= cfg_data;
        fsgs_pkg::CFG_TIME_STEP: time_step <= cfg_data;
        fsgs_pkg::CFG_BASE_DIST: base_dist <= cfg_data;
        default: ;
      endcase
    end
  end

  // diagonal distance, saturated
  logic [31:0] diag_prod;
  assign diag_prod = 32'(base_dist) * 32'(fsgs_pkg::SQRT2_Q15);

  always_ff @(posedge clk) begin
    diag <= (diag_prod[31] != 1'b0) ? 16'hFFFF : diag_prod[30:15];
  end

  // ignition cell address
  logic          ign_in_grid;
  logic [AW-1:0] ign_addr;
  assign ign_in_grid = (32'(ign_row) < 32'(ROWS)) && (32'(ign_col) < 32'(COLS));
  assign ign_addr    = AW'(32'(ign_row) * 32'(COLS) + 32'(ign_col));

  // read request address
  logic          rd_in_grid;
  logic [AW-1:0] rd_addr;
  assign rd_in_grid = (32'(cell_row) < 32'(ROWS)) && (32'(cell_col) < 32'(COLS));
  assign rd_addr    = AW'(32'(cell_row) * 32'(COLS) + 32'(cell_col));

  // memories
  fsgs_pkg::cell_t cmem [CELLS];
  fsgs_pkg::cell_t cmem_rd;
  fsgs_pkg::cell_t cmem_wdata;
  logic [AW-1:0]   cmem_raddr;
  logic [AW-1:0]   cmem_waddr;
  logic            cmem_we;

  logic [DW-1:0]   dmem [CELLS];
  logic [DW-1:0]   dmem_rd;
  logic [DW-1:0]   dmem_wdata;
  logic [AW-1:0]   dmem_raddr;
  logic [AW-1:0]   dmem_waddr;
  logic            dmem_we;

  always_ff @(posedge clk) begin
    if (cmem_we) begin
      cmem[cmem_waddr] <= cmem_wdata;
    end
    cmem_rd <= cmem[cmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_waddr] <= dmem_wdata;
    end
    dmem_rd <= dmem[dmem_raddr];
  end

  // sweep control
  logic [CNTW-1:0] cnt;
  logic [RW-1:0]   d_row;
  logic [CW-1:0]   d_col;
  logic [15:0]     step_counter;
  logic            rd_ok;
  logic            proc_valid;

  assign proc_valid = (state == S_ADV) && (cnt >= CNT_PROC_LO);

  // line buffer: win[0] registers the cell memory read data, win[j] registers win[j-1]
  fsgs_pkg::win_t win [WLEN];
  logic [31:0]    dec_prod;
  assign dec_prod = 32'(cmem_rd.rate) * 32'(time_step);

  always_ff @(posedge clk) begin
    win[0].burn <= cmem_rd.burn;
    win[0].rate <= cmem_rd.rate;
    win[0].dec  <= (dec_prod[31:24] != 8'd0) ? 16'hFFFF : dec_prod[23:8];
    for (int j = 1; j < WLEN; j++) begin
      win[j] <= win[j-1];
    end
  end

  // per-direction update of the destination cell
  logic [DW-1:0]             lane_out;
  logic [fsgs_pkg::NDIR-1:0] hit;
  logic [15:0]               src_rate [fsgs_pkg::NDIR];
  fsgs_pkg::win_t            own;

  assign own = win[COLS + 1];

  for (genvar n = 0; n < fsgs_pkg::NDIR; n++) begin : g_dir
    localparam int SR  = -fsgs_pkg::DROW[n];
    localparam int SC  = -fsgs_pkg::DCOL[n];
    localparam int TAP = COLS + 1 - SR * COLS - SC;

    fsgs_pkg::win_t src;
    logic           row_ok;
    logic           col_ok;
    logic           act;
    logic [15:0]    old_dist;
    logic [15:0]    newd;

    assign src      = win[TAP];
    assign row_ok   = (SR == 0) || ((SR < 0) ? (d_row != '0) : (d_row != ROW_LAST));
    assign col_ok   = (SC == 0) || ((SC < 0) ? (d_col != '0) : (d_col != COL_LAST));
    assign act      = row_ok && col_ok && src.burn && !own.burn;
    assign old_dist = dmem_rd[16*n +: 16];
    assign newd     = (old_dist > src.dec) ? (old_dist - src.dec) : 16'd0;

    assign lane_out[16*n +: 16] = act ? newd : old_dist;
    assign hit[n]               = act && (newd == 16'd0);
    assign src_rate[n]          = src.rate;
  end

  // last writer in scan order wins the rate
  logic [15:0] sel_rate;
  always_comb begin
    sel_rate = 16'd0;
    for (int i = 0; i < fsgs_pkg::NDIR; i++) begin
      if (hit[fsgs_pkg::PRIO[i]]) begin
        sel_rate = src_rate[fsgs_pkg::PRIO[i]];
      end
    end
  end

  // fill word for restart
  logic [DW-1:0] fill_word;
  always_comb begin
    for (int n = 0; n < fsgs_pkg::NDIR; n++) begin
      fill_word[16*n +: 16] = n[0] ? diag : base_dist;
    end
  end

  // memory access steering
  always_comb begin
    cmem_raddr = AW'(cnt);
    cmem_waddr = AW'(cnt);
    cmem_wdata = '0;
    cmem_we    = 1'b0;
    dmem_raddr = AW'(cnt - CNT_DRD_OFS);
    dmem_waddr = AW'(cnt);
    dmem_wdata = fill_word;
    dmem_we    = 1'b0;
    case (state)
      S_IDLE: begin
        cmem_raddr = rd_addr;
      end
      S_CLEAR: begin
        cmem_we = 1'b1;
      end
      S_FILL: begin
        cmem_we = 1'b1;
        dmem_we = 1'b1;
        if (ign_in_grid && (AW'(cnt) == ign_addr)) begin
          cmem_wdata.burn = 1'b1;
          cmem_wdata.rate = ign_rate;
        end
      end
      S_ADV: begin
        cmem_waddr         = AW'(cnt - CNT_DST_OFS);
        dmem_waddr         = AW'(cnt - CNT_DST_OFS);
        dmem_wdata         = lane_out;
        dmem_we            = proc_valid;
        cmem_we            = proc_valid && (hit != '0);
        cmem_wdata.burn    = 1'b1;
        cmem_wdata.rate    = sel_rate;
        cmem_wdata.arrival = step_counter;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      d_row        <= '0;
      d_col        <= '0;
      step_counter <= '0;
      rd_ok        <= 1'b0;
      out_valid    <= 1'b0;
      arrival_step <= '0;
      ignited      <= 1'b0;
      step_count   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_FILL_END) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt   <= '0;
          d_row <= '0;
          d_col <= '0;
          if (in_valid && in_ready) begin
            case (req_type)
              fsgs_pkg::REQ_RESTART: begin
                step_counter <= '0;
                state        <= S_FILL;
              end
              fsgs_pkg::REQ_ADVANCE: begin
                state <= S_ADV;
              end
              fsgs_pkg::REQ_READ: begin
                rd_ok <= rd_in_grid;
                state <= S_READ;
              end
              default: begin
                out_valid    <= 1'b1;
                arrival_step <= '0;
                ignited      <= 1'b0;
                step_count   <= step_counter;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid    <= 1'b1;
          arrival_step <= rd_ok ? cmem_rd.arrival : 16'd0;
          ignited      <= rd_ok && cmem_rd.burn;
          step_count   <= step_counter;
          state        <= S_IDLE;
        end
        S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_FILL_END) begin
            out_valid    <= 1'b1;
            arrival_step <= '0;
            ignited      <= 1'b0;
            step_count   <= step_counter;
            state        <= S_IDLE;
          end
        end
        S_ADV: begin
          cnt <= cnt + 1'b1;
          if (proc_valid) begin
            if (d_col == COL_LAST) begin
              d_col <= '0;
              d_row <= d_row + 1'b1;
            end else begin
              d_col <= d_col + 1'b1;
            end
          end
          if (cnt == CNT_ADV_END) begin
            out_valid    <= 1'b1;
            arrival_step <= '0;
            ignited      <= 1'b0;
            step_count   <= (step_counter == 16'hFFFF) ? step_counter
                                                        : step_counter + 16'd1;
            if (step_counter != 16'hFFFF) begin
              step_counter <= step_counter + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
